/* sv/deque_with_value_remove_top_defines.svh */
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent assertion forms for the deque block.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_VALUE_REMOVE_TOP_DEFINES_SVH
`define DEQUE_WITH_VALUE_REMOVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DEQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Widths, operation and status codes and shared types of the deque block.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_CAPACITY = 16;
   localparam int DATA_W       = 32;
   localparam int MODE_W       = 3;
   localparam int STATUS_W     = 2;

   // operation codes carried in the request mode field
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_REMOVE     = 3'd4,
      MODE_SEARCH     = 3'd5
   } deq_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } deq_status_type;

   // result flags handed from the sequencer to the response stage
   typedef struct packed {
      logic           found;
      deq_status_type status;
   } deq_flags_type;

endpackage

/* sv/deq_if.sv */
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready request and response channels of the deque block.
// ----------------------------------------------------------------------------
interface deq_req_if;
   import deq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if #(
   parameter int CNT_W = $clog2(deq_pkg::DEQ_CAPACITY + 1)
);
   import deq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped_value;
   logic                     found;
   logic [STATUS_W-1:0]      status;
   logic [CNT_W-1:0]         entry_count;
   logic signed [DATA_W-1:0] front_value;

   modport source (output valid, output popped_value, output found, output status,
                   output entry_count, output front_value, input ready);
   modport sink   (input valid, input popped_value, input found, input status,
                   input entry_count, input front_value, output ready);
endinterface

/* sv/deq_ram.sv */
// ----------------------------------------------------------------------------
// Deque entry RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* sv/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// Deque sequencer
// Runs one operation at a time over the entry RAM through a shared ring
// address unit and a single compare/move loop.
// ----------------------------------------------------------------------------
`include "deque_with_value_remove_top_defines.svh"

module deq_ctrl #(
   parameter int CAPACITY = deq_pkg::DEQ_CAPACITY,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [deq_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [deq_pkg::DATA_W-1:0] req_value,
   // result side
   output logic                              res_valid,
   input  logic                              res_ready,
   output logic signed [deq_pkg::DATA_W-1:0] popped_value,
   output deq_pkg::deq_flags_type            flags,
   output logic [CNT_W-1:0]                  entry_count,
   output logic signed [deq_pkg::DATA_W-1:0] front_value,
   // entry RAM
   output logic                              wr_en,
   output logic [IDX_W-1:0]                  wr_addr,
   output logic [deq_pkg::DATA_W-1:0]        wr_data,
   output logic                              rd_en,
   output logic [IDX_W-1:0]                  rd_addr,
   input  logic [deq_pkg::DATA_W-1:0]        rd_data
);
   import deq_pkg::*;

   localparam int SUM_W = IDX_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POP_WAIT,
      ST_SCAN,
      ST_SHIFT,
      ST_FRONT_RD,
      ST_FRONT_WAIT,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;
   logic                     found_ff, found_in;
   deq_status_type           status_ff, status_in;
   logic signed [DATA_W-1:0] frontval_ff, frontval_in;

   logic [CNT_W-1:0]         rd_pos;
   logic [CNT_W-1:0]         wr_pos;
   logic                     is_full;
   logic                     is_empty;

   // map a position counted from the front onto a ring slot
   function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(ofs);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // shared ring address unit for both RAM ports
   assign rd_addr = ring_slot(front_ff, rd_pos);
   assign wr_addr = ring_slot(front_ff, wr_pos);

   // sequencer next state and RAM control
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      value_in    = value_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pos_in      = pos_ff;
      rd_vld_in   = 1'b0;
      popped_in   = popped_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      frontval_in = frontval_ff;
      rd_en       = 1'b0;
      rd_pos      = '0;
      wr_en       = 1'b0;
      wr_pos      = '0;
      wr_data     = value_ff;
      req_ready   = (state_ff == ST_IDLE);
      res_valid   = (state_ff == ST_DONE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               value_in  = req_value;
               popped_in = '0;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               state_in  = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            scan_in  = '0;
            pos_in   = '0;
            state_in = ST_FRONT_RD;
            case (mode_ff)
               MODE_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     // slot one before the front
                     wr_en    = 1'b1;
                     wr_pos   = CNT_W'(CAPACITY - 1);
                     front_in = ring_slot(front_ff, CNT_W'(CAPACITY - 1));
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_pos   = count_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               MODE_POP_FRONT: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_pos   = '0;
                     state_in = ST_POP_WAIT;
                  end
               end
               MODE_POP_BACK: begin
                  if (is_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_pos   = count_ff - 1'b1;
                     state_in = ST_POP_WAIT;
                  end
               end
               MODE_REMOVE, MODE_SEARCH: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_FRONT_RD;
               end
            endcase
         end

         ST_POP_WAIT: begin
            popped_in = rd_data;
            count_in  = count_ff - 1'b1;
            if (mode_ff == MODE_POP_FRONT) begin
               front_in = ring_slot(front_ff, CNT_W'(1));
            end
            state_in = ST_FRONT_RD;
         end

         ST_SCAN: begin
            // stream reads from the front, compare each word in the cycle after its read
            if (scan_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_pos    = scan_ff;
               scan_in   = scan_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_data == value_ff) begin
                  found_in = 1'b1;
                  state_in = (mode_ff == MODE_REMOVE) ? ST_SHIFT : ST_FRONT_RD;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff + 1'b1 == count_ff) begin
                     state_in = ST_FRONT_RD;
                  end
               end
            end else if (is_empty) begin
               state_in = ST_FRONT_RD;
            end
         end

         ST_SHIFT: begin
            // move each later entry one place toward the front
            if (scan_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_pos    = scan_ff;
               scan_in   = scan_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_pos  = pos_ff;
               wr_data = rd_data;
               pos_in  = pos_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_FRONT_RD;
            end
         end

         ST_FRONT_RD: begin
            if (!is_empty) begin
               rd_en  = 1'b1;
               rd_pos = '0;
            end
            state_in = ST_FRONT_WAIT;
         end

         ST_FRONT_WAIT: begin
            frontval_in = is_empty ? '0 : rd_data;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered results
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         front_ff  <= '0;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      scan_ff     <= scan_in;
      pos_ff      <= pos_in;
      popped_ff   <= popped_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      frontval_ff <= frontval_in;
   end

   assign popped_value = popped_ff;
   assign flags.found  = found_ff;
   assign flags.status = status_ff;
   assign entry_count  = count_ff;
   assign front_value  = frontval_ff;

   // checks
   `DEQ_ASSERT_IMPL(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !wr_en,
      "entry RAM written while idle")
   `DEQ_ASSERT_IMPL(a_full_count, clock, reset,
      res_valid && flags.status == STATUS_FULL, count_ff == CNT_W'(CAPACITY),
      "full status reported below capacity")
   `DEQ_ASSERT_IMPL(a_empty_pop, clock, reset,
      res_valid && flags.status == STATUS_EMPTY, count_ff == '0 && popped_value == '0,
      "empty status with entries or a popped value")
   `DEQ_ASSERT_NEXT(a_result_hold, clock, reset, res_valid && !res_ready,
      res_valid && $stable(count_ff) && $stable(front_ff),
      "result dropped or store changed while waiting")

endmodule

/* sv/deque_with_value_remove_top.sv */
// Deque with remove-by-value: one operation per request, one response each.
// Every operation ends with a read of the front entry before its result is registered;
// pops add a wait for the read entry, and search and remove scan the stored entries.
// One request at a time: a new request is accepted only once the previous result has
// moved to the response register, and a held response stalls requests.
// Reset clears front pointer and count; entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Deque top level
// Sequencer, entry RAM and response output register of the deque block.
// ----------------------------------------------------------------------------
module deque_with_value_remove_top #(
   parameter int CAPACITY = deq_pkg::DEQ_CAPACITY,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req,
   deq_rsp_if.source  rsp
);
   import deq_pkg::*;

   logic                     res_valid;
   logic                     res_ready;
   logic signed [DATA_W-1:0] res_popped;
   deq_flags_type            res_flags;
   logic [CNT_W-1:0]         res_count;
   logic signed [DATA_W-1:0] res_front;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic                     rsp_vld_ff, rsp_vld_in;
   logic signed [DATA_W-1:0] rsp_popped_ff;
   deq_flags_type            rsp_flags_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic signed [DATA_W-1:0] rsp_front_ff;
   logic                     rsp_load;

   deq_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_ready    (req.ready),
      .req_mode     (req.mode),
      .req_value    (req.value),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .popped_value (res_popped),
      .flags        (res_flags),
      .entry_count  (res_count),
      .front_value  (res_front),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // load the response register when it is empty or being drained
   assign res_ready  = !rsp_vld_ff || rsp.ready;
   assign rsp_load   = res_valid && res_ready;
   assign rsp_vld_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);

   // hold the response until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (rsp_load) begin
         rsp_popped_ff <= res_popped;
         rsp_flags_ff  <= res_flags;
         rsp_count_ff  <= res_count;
         rsp_front_ff  <= res_front;
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.popped_value = rsp_popped_ff;
   assign rsp.found        = rsp_flags_ff.found;
   assign rsp.status       = rsp_flags_ff.status;
   assign rsp.entry_count  = rsp_count_ff;
   assign rsp.front_value  = rsp_front_ff;

endmodule

/* dv/tb_deque_with_value_remove_top.sv */
// ----------------------------------------------------------------------------
// Deque with remove-by-value testbench
// Drives push, pop, remove-by-value, search and unused operation codes into
// the deque over its request channel, predicts every response from a private
// model of the ring, and compares each response field by field. Both channel
// sides idle at random, and the response side holds off for long stretches
// so that the block backs up and stalls its request input.
// ----------------------------------------------------------------------------
module tb_deque_with_value_remove_top;
   import deq_pkg::*;

   localparam int COUNT_W     = $clog2(DEQ_CAPACITY + 1);
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 2 * DEQ_CAPACITY + 20;
   localparam int RANDOM_OPS  = 1700;

   // codes the block treats as no operation
   localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0]   popped_value;
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [DATA_W-1:0]   front_value;
   } deq_result_type;

   // -------------------------------------------------------------------------
   // Ring model and store of expected responses
   // -------------------------------------------------------------------------
   class deque_scoreboard;
      logic [DATA_W-1:0] ring[DEQ_CAPACITY];
      int                head;
      int                depth;
      deq_result_type    expected_rsp[$];
      int                mismatches;

      function new();
         head       = 0;
         depth      = 0;
         mismatches = 0;
      endfunction

      function int slot(int pos);
         return (head + pos) % DEQ_CAPACITY;
      endfunction

      // apply one transferred request to the ring and queue its response
      function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
         deq_result_type r;
         int             pos;
         r        = '0;
         r.status = STATUS_OK;
         case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (depth >= DEQ_CAPACITY) begin
                  r.status = STATUS_FULL;
               end else if (mode == MODE_PUSH_FRONT) begin
                  head       = (head + DEQ_CAPACITY - 1) % DEQ_CAPACITY;
                  ring[head] = value;
                  depth++;
               end else begin
                  ring[slot(depth)] = value;
                  depth++;
               end
            end
            MODE_POP_FRONT: begin
               if (depth == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.popped_value = ring[head];
                  head           = (head + 1) % DEQ_CAPACITY;
                  depth--;
               end
            end
            MODE_POP_BACK: begin
               if (depth == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.popped_value = ring[slot(depth - 1)];
                  depth--;
               end
            end
            MODE_REMOVE, MODE_SEARCH: begin
               for (pos = 0; pos < depth; pos++) begin
                  if (ring[slot(pos)] == value) begin
                     r.found = 1'b1;
                     break;
                  end
               end
               // close the gap behind the first match
               if (r.found && mode == MODE_REMOVE) begin
                  for (; pos + 1 < depth; pos++)
                     ring[slot(pos)] = ring[slot(pos + 1)];
                  depth--;
               end
            end
            default: begin
            end
         endcase
         r.entry_count = COUNT_W'(depth);
         r.front_value = (depth > 0) ? ring[head] : '0;
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                  logic [DATA_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      // check one transferred response against the oldest expectation
      function void check_response(deq_result_type got);
         deq_result_type exp_r;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         exp_r = expected_rsp.pop_front();
         compare_field("popped_value", exp_r.popped_value, got.popped_value);
         compare_field("found", exp_r.found, got.found);
         compare_field("status", exp_r.status, got.status);
         compare_field("entry_count", exp_r.entry_count, got.entry_count);
         compare_field("front_value", exp_r.front_value, got.front_value);
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   bit              no_idle;
   int              cycle_count;
   int              responses_seen;
   deque_scoreboard board;

   deq_req_if req_if ();
   deq_rsp_if rsp_if ();

   deque_with_value_remove_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_deque_with_value_remove_top failed");
         $finish;
      end
   end

   // mostly no idle, often a short one, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // values from a small pool so that searches and removes hit often
   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] pool[8];
      pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0000_0003, 32'h8000_0003, 32'h0000_0001, 32'hA5A5_A5A5};
      if ($urandom_range(0, 3) == 0)
         return $urandom;
      return pool[$urandom_range(0, 7)];
   endfunction

   // lean toward pushes or pops so the count sweeps between empty and full
   function automatic logic [MODE_W-1:0] pick_mode(bit fill_lean);
      int r;
      r = $urandom_range(0, 99);
      if (r >= 96)
         return (r < 98) ? MODE_UNUSED_6 : MODE_UNUSED_7;
      if (fill_lean) begin
         if (r < 30) return MODE_PUSH_FRONT;
         if (r < 60) return MODE_PUSH_BACK;
         if (r < 68) return MODE_POP_FRONT;
         if (r < 76) return MODE_POP_BACK;
         if (r < 86) return MODE_REMOVE;
         return MODE_SEARCH;
      end
      if (r < 15) return MODE_PUSH_FRONT;
      if (r < 30) return MODE_PUSH_BACK;
      if (r < 50) return MODE_POP_FRONT;
      if (r < 70) return MODE_POP_BACK;
      if (r < 83) return MODE_REMOVE;
      return MODE_SEARCH;
   endfunction

   // offer one request, hold it until transfer, then idle at random
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
      int gap;
      req_if.valid <= 1'b1;
      req_if.mode  <= mode;
      req_if.value <= value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_request(mode, value);
      gap = no_idle ? 0 : idle_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // take responses, stall at random, and hold off twice for a long stretch
   task automatic take_responses();
      deq_result_type got;
      int             stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.popped_value = rsp_if.popped_value;
            got.found        = rsp_if.found;
            got.status       = rsp_if.status;
            got.entry_count  = rsp_if.entry_count;
            got.front_value  = rsp_if.front_value;
            board.check_response(got);
            responses_seen++;
            if (responses_seen == 150 || responses_seen == 1000)
               stall_left = 300;
         end
         if (stall_left == 0 && !no_idle)
            stall_left = idle_length();
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   endtask

   initial begin
      int k;
      bit fill_lean;

      board          = new();
      responses_seen = 0;
      no_idle        = 1'b0;
      fill_lean      = 1'b0;
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.mode   <= MODE_PUSH_FRONT;
      req_if.value  <= '0;
      rsp_if.ready  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      fork
         take_responses();
      join_none

      // empty store: pops report empty, search and remove miss, unused codes
      send_request(MODE_POP_FRONT, 32'h0);
      send_request(MODE_POP_BACK, 32'h0);
      send_request(MODE_SEARCH, 32'h0);
      send_request(MODE_REMOVE, 32'h0);
      send_request(MODE_UNUSED_6, 32'hFFFF_FFFF);
      send_request(MODE_UNUSED_7, 32'h0);

      // fill from both ends with extreme words, then push on a full store
      send_request(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(MODE_PUSH_BACK, 32'h8000_0000);
      send_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(MODE_PUSH_BACK, 32'h0000_0000);
      for (k = 4; k < DEQ_CAPACITY; k++)
         send_request(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom);
      send_request(MODE_PUSH_FRONT, 32'h1234_5678);
      send_request(MODE_PUSH_BACK, 32'h1234_5678);

      // hit and miss on the full store, remove from the middle, then pop
      send_request(MODE_SEARCH, 32'h8000_0000);
      send_request(MODE_REMOVE, 32'h8000_0000);
      send_request(MODE_REMOVE, 32'h8000_0000);
      send_request(MODE_POP_FRONT, 32'h0);
      send_request(MODE_POP_BACK, 32'h0);
      send_request(MODE_UNUSED_6, 32'h0);

      // random operations in phases that alternate fill and drain bias
      for (k = 0; k < RANDOM_OPS; k++) begin
         if (k % 120 == 0) begin
            fill_lean = ~fill_lean;
            no_idle   = ((k / 120) % 4 == 3);
         end
         send_request(pick_mode(fill_lean), pick_value());
      end
      no_idle       = 1'b0;
      req_if.valid <= 1'b0;

      // drain the outstanding responses, then let the block settle
      while (board.pending() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb_deque_with_value_remove_top passed");
      else
         $display("tb_deque_with_value_remove_top failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/deque_with_value_remove_top.sv
dv/tb_deque_with_value_remove_top.sv
